// ===== sv/range_add_range_max_tree_core_defines.svh =====
// Assertion macros for the range add / range maximum tree core
`ifndef RANGE_ADD_RANGE_MAX_TREE_CORE_DEFINES_SVH
`define RANGE_ADD_RANGE_MAX_TREE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// hold cons in the same cycle as ante
`define RAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rar: same-cycle check failed");
// hold cons in the cycle after ante
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rar: next-cycle check failed");
`else
`define RAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/rar_pkg.sv =====
`default_nettype none
package rar_pkg;
	localparam int LEAVES     = 1024;
	localparam int LOG        = $clog2(LEAVES);
	localparam int POS_W      = 10;
	localparam int NODE_AW    = LOG + 1;
	localparam int NODE_DEPTH = 2 * LEAVES;
	localparam int VAL_W      = 40;
	localparam int AMT_W      = 32;
	localparam int NODE_W     = 2 * VAL_W;
	localparam int LVL_W      = $clog2(LOG + 1);

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VISIT,
		ST_CHECK,
		ST_FULLV,
		ST_PUSH0,
		ST_PUSH1,
		ST_RET,
		ST_UPD0,
		ST_UPD1,
		ST_UPD2
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] max_v;
		logic signed [VAL_W-1:0] pend;
	} node_t;

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
		end else begin
			sat_add = s[VAL_W-1:0];
		end
	endfunction

	function automatic logic signed [VAL_W-1:0] smax(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		smax = (a > b) ? a : b;
	endfunction
endpackage
`default_nettype wire

// ===== sv/range_add_range_max_tree_core.sv =====
// Range add / range maximum tree: 1024 signed 40-bit positions, lazy adds per node.
// Each node takes VISIT, CHECK, RET; FULLV if fully covered; PUSH0/1, UPD0-2 if split.
// busy is high during a walk; an empty range answers the cycle after start, busy low.
// Throughput is one item per walk: the single node RAM (one read, one write port)
// sets it. The receiver cannot stall: done is a one-cycle strobe.
// After reset the block clears all 2048 nodes, one per cycle, with busy high.
`default_nettype none
`include "range_add_range_max_tree_core_defines.svh"
module range_add_range_max_tree_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             op,
	input  wire logic [rar_pkg::POS_W-1:0]        range_low,
	input  wire logic [rar_pkg::POS_W-1:0]        range_high,
	input  wire logic signed [rar_pkg::AMT_W-1:0] add_amount,
	output logic                                  busy,
	output logic                                  done,
	output logic signed [rar_pkg::VAL_W-1:0]      range_max,
	output logic                                  range_empty
);
	import rar_pkg::*;

	// sequencer and walk position
	state_t state_q, state_d;
	logic [NODE_AW-1:0] n_q;
	logic [LVL_W-1:0]   level_q;
	logic [NODE_AW-1:0] clr_q;

	// item held for the walk
	logic              is_add_q;
	logic [POS_W-1:0]  ql_q, qh_q;
	logic signed [VAL_W-1:0] amt_q;

	// node data and running results
	logic signed [VAL_W-1:0] max_q, pend_q, lv_q, acc_q;
	logic                    done_q, empty_q;
	logic signed [VAL_W-1:0] result_q;

	// RAM port
	logic               ram_we;
	logic [NODE_AW-1:0] ram_wa, ram_ra;
	node_t              ram_wd, rd_node;
	logic [NODE_W-1:0]  ram_rd;

	rar_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
		.clk(clk),
		.we (ram_we),
		.wa (ram_wa),
		.wd (ram_wd),
		.ra (ram_ra),
		.rd (ram_rd)
	);

	assign rd_node = node_t'(ram_rd);

	// span of the current node: aligned block of 2^(LOG-level) positions
	logic [LVL_W-1:0]       sh;
	logic [NODE_AW+LOG-1:0] lo_wide;
	logic [LOG-1:0]         node_lo, node_hi, span_mask;
	logic                   disjoint, covered;
	logic [NODE_AW-1:0]     child_l, child_r;
	logic signed [VAL_W-1:0] full_pend, push_pend, child_val;

	always_comb begin
		sh        = LVL_W'(LOG) - level_q;
		lo_wide   = {{LOG{1'b0}}, n_q} << sh;
		node_lo   = lo_wide[LOG-1:0];
		span_mask = ~({LOG{1'b1}} << sh);
		node_hi   = node_lo | span_mask;
		disjoint  = (qh_q < node_lo) || (node_hi < ql_q);
		covered   = (ql_q <= node_lo) && (node_hi <= qh_q);
		child_l   = {n_q[NODE_AW-2:0], 1'b0};
		child_r   = {n_q[NODE_AW-2:0], 1'b1};
		full_pend = sat_add(rd_node.pend, amt_q);
		push_pend = sat_add(rd_node.pend, pend_q);
		child_val = sat_add(rd_node.max_v, rd_node.pend);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_AW'(NODE_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && (range_low <= range_high)) state_d = ST_VISIT;
			end
			ST_VISIT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (disjoint) state_d = ST_RET;
				else if (covered) state_d = ST_FULLV;
				else state_d = ST_PUSH0;
			end
			ST_FULLV: state_d = ST_RET;
			ST_PUSH0: state_d = ST_PUSH1;
			ST_PUSH1: state_d = ST_VISIT;
			ST_RET: begin
				if (n_q == NODE_AW'(1)) state_d = ST_IDLE;
				else if (!n_q[0]) state_d = ST_VISIT;
				else state_d = ST_UPD0;
			end
			ST_UPD0: state_d = ST_UPD1;
			ST_UPD1: state_d = ST_UPD2;
			ST_UPD2: state_d = ST_RET;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_we = 1'b0;
		ram_wa = n_q;
		ram_wd = '0;
		ram_ra = n_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
			end
			ST_CHECK: begin
				if (!disjoint && covered && is_add_q) begin
					ram_we = 1'b1;
					ram_wd = '{max_v: rd_node.max_v, pend: full_pend};
				end else if (!disjoint && !covered) begin
					// clear own pending add, fetch left child
					ram_we = 1'b1;
					ram_wd = '{max_v: rd_node.max_v, pend: '0};
					ram_ra = child_l;
				end
			end
			ST_PUSH0: begin
				ram_we = 1'b1;
				ram_wa = child_l;
				ram_wd = '{max_v: rd_node.max_v, pend: push_pend};
				ram_ra = child_r;
			end
			ST_PUSH1: begin
				ram_we = 1'b1;
				ram_wa = child_r;
				ram_wd = '{max_v: rd_node.max_v, pend: push_pend};
			end
			ST_UPD0: ram_ra = child_l;
			ST_UPD1: ram_ra = child_r;
			ST_UPD2: begin
				ram_we = 1'b1;
				ram_wd = '{max_v: smax(lv_q, child_val), pend: '0};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			n_q     <= NODE_AW'(1);
			level_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + NODE_AW'(1);
				ST_IDLE: begin
					if (start) begin
						n_q     <= NODE_AW'(1);
						level_q <= '0;
						// an empty range answers at once
						done_q  <= (range_low > range_high);
					end
				end
				ST_PUSH1: begin
					n_q     <= child_l;
					level_q <= level_q + LVL_W'(1);
				end
				ST_RET: begin
					if (n_q == NODE_AW'(1)) begin
						done_q <= 1'b1;
					end else if (!n_q[0]) begin
						n_q <= n_q + NODE_AW'(1);
					end else begin
						n_q     <= n_q >> 1;
						level_q <= level_q - LVL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					is_add_q <= (op == OP_ADD);
					ql_q     <= range_low;
					qh_q     <= range_high;
					amt_q    <= VAL_W'(add_amount);
					acc_q    <= VAL_MIN;
					result_q <= VAL_MIN;
					empty_q  <= (range_low > range_high);
				end
			end
			ST_CHECK: begin
				max_q  <= rd_node.max_v;
				pend_q <= (covered && is_add_q) ? full_pend : rd_node.pend;
			end
			ST_FULLV: acc_q <= smax(acc_q, sat_add(max_q, pend_q));
			ST_UPD1:  lv_q  <= child_val;
			ST_RET: begin
				if (n_q == NODE_AW'(1)) begin
					result_q <= acc_q;
					empty_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign range_max   = result_q;
	assign range_empty = empty_q;

	// the strobe comes only once the walk has returned to idle
	`RAR_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// a non-empty item starts a walk
	`RAR_ASSERT_NEXT(a_start_walk, clk, arst_n, start && !busy && (range_low <= range_high), busy)
	// the walk never writes the unused node 0
	`RAR_ASSERT_IMPL(a_no_node0, clk, arst_n, ram_we && (state_q != ST_CLEAR), ram_wa != '0)
	// an empty answer carries the minimum value
	`RAR_ASSERT_IMPL(a_empty_min, clk, arst_n, done && range_empty, range_max == VAL_MIN)
endmodule
`default_nettype wire

// ===== sv/rar_ram.sv =====
`default_nettype none
module rar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wa,
	input  wire logic [WIDTH-1:0]         wd,
	input  wire logic [$clog2(DEPTH)-1:0] ra,
	output logic      [WIDTH-1:0]         rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule
`default_nettype wire
